/* hdl/mvf_pkg.sv */
// Package for max_value_frequency: item types, chain token and sizing constants.
// No dependencies; used by every module in hdl/.
package mvf_pkg;

    localparam int DISTINCT_ENTRIES = 64;
    localparam int MAX_SET_ITEMS    = 1024;
    localparam int ELEM_W           = 32;
    localparam int CNT_W            = $clog2(MAX_SET_ITEMS + 1);

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last_element;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] max_count;
        logic             overflow;
    } out_item_t;

    // Item as it travels down the cell chain.
    typedef struct packed {
        logic              valid;
        logic [ELEM_W-1:0] value;
        logic              last;
        logic              found;   // some cell matched or claimed the value
        logic              ovf;     // set length bound exceeded on entry
        logic [CNT_W-1:0]  count;   // entry count after this item, when found
    } token_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_SET_ITEMS);
        return (c >= lim) ? lim : c + CNT_W'(1);
    endfunction

endpackage

/* hdl/mvf_cell.sv */
// One table entry of the distinct-value chain, with its token stage.
// Depends on mvf_pkg.
module mvf_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  mvf_pkg::token_t tok_in,
    output mvf_pkg::token_t tok_out
);
    import mvf_pkg::*;

    logic              used_reg;
    logic [ELEM_W-1:0] value_reg;
    logic [CNT_W-1:0]  count_reg;
    token_t            tok_reg;

    logic             hit;
    logic             claim;
    logic [CNT_W-1:0] count_next;
    token_t           tok_next;

    assign hit        = tok_in.valid && !tok_in.found && used_reg
                        && (value_reg == tok_in.value);
    assign claim      = tok_in.valid && !tok_in.found && !used_reg;
    assign count_next = hit ? sat_inc(count_reg) : CNT_W'(1);

    always_comb
    begin
        tok_next = tok_in;
        if (hit || claim)
        begin
            tok_next.found = 1'b1;
            tok_next.count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
            // the last item of a set clears the entry behind itself
            if (tok_in.valid && tok_in.last)
                used_reg <= 1'b0;
            else if (claim)
                used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (hit || claim))
            count_reg <= count_next;
        if (advance && claim)
            value_reg <= tok_in.value;
    end

    assign tok_out = tok_reg;

endmodule

/* hdl/mvf_result.sv */
// Chain tail: running maximum, overflow collection and output register.
// Depends on mvf_pkg.
module mvf_result (
    input  logic               clk,
    input  logic               rst_n,
    input  mvf_pkg::token_t    tok_in,
    output logic               advance,
    output logic               result_valid,
    input  logic               result_ready,
    output mvf_pkg::out_item_t result
);
    import mvf_pkg::*;

    logic [CNT_W-1:0] best_reg;
    logic             ovf_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] best_next;
    logic             ovf_next;
    logic             emit;

    // hold the chain only when a finished set has nowhere to go
    assign advance   = !(tok_in.valid && tok_in.last && out_valid_reg && !result_ready);
    assign cnt       = tok_in.found ? tok_in.count : '0;
    assign best_next = (cnt > best_reg) ? cnt : best_reg;
    assign ovf_next  = ovf_reg || tok_in.ovf || !tok_in.found;
    assign emit      = advance && tok_in.valid && tok_in.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && tok_in.valid)
            begin
                if (tok_in.last)
                begin
                    best_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
                else
                begin
                    best_reg <= best_next;
                    ovf_reg  <= ovf_next;
                end
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.max_count <= best_next;
            out_reg.overflow  <= ovf_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* hdl/max_value_frequency.sv */
// Top level of max_value_frequency: input stage, chain of table cells, result tail.
// Depends on mvf_pkg, mvf_cell and mvf_result.
//
// Usage: items (one signed 32-bit element each, last_element marks the end of a
// set) enter on item_valid/item_ready. For each set one result leaves on
// result_valid/result_ready: max_count, the occurrence count of the most
// frequent element (saturating at MAX_SET_ITEMS), and overflow, set when the
// set held more distinct elements than DISTINCT_ENTRIES or more items than
// MAX_SET_ITEMS.
// Throughput: one item per cycle while the row is not held. Each item walks the row of
// DISTINCT_ENTRIES cells, one cell per cycle while the row advances, and a set's
// result is registered at the tail once its last item leaves the last cell (when the output is free).
// The last item of a set clears each table entry as it passes it, so the next
// set may follow in the very next cycle.
// Reset empties the table, the running maximum and the output register.
// When the receiver stalls with a result pending, the row keeps moving until
// the next set's last item reaches the tail; then the whole row and the input
// hold until the pending result is taken.
module max_value_frequency (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mvf_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output mvf_pkg::out_item_t result
);
    import mvf_pkg::*;

    logic             advance;
    logic [CNT_W-1:0] items_seen_reg;
    logic             too_long;
    token_t           chain [DISTINCT_ENTRIES+1];

    assign item_ready = advance;
    assign too_long   = (items_seen_reg >= CNT_W'(MAX_SET_ITEMS));

    // set length count at the entry of the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            items_seen_reg <= '0;
        else if (item_valid && advance)
        begin
            if (item.last_element)
                items_seen_reg <= '0;
            else if (!too_long)
                items_seen_reg <= items_seen_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        chain[0].valid = item_valid;
        chain[0].value = item.element;
        chain[0].last  = item.last_element;
        chain[0].found = 1'b0;
        chain[0].ovf   = too_long;
        chain[0].count = '0;
    end

    for (genvar i = 0; i < DISTINCT_ENTRIES; i++)
    begin : g_cell
        mvf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    mvf_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_in       (chain[DISTINCT_ENTRIES]),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
